// ----- design/baro_pkg.sv -----
// Package: widths, register indexes, constants and multiply helpers for the compensation block.
`default_nettype none
package baro_pkg;
    localparam int RAW_W      = 20;
    localparam int DIV_W      = 64;
    localparam int SIDE_W     = 34;   // temperature, invalid flag, quotient sign
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_P9    = 3'd3;

    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] P_BASE      = 21'd1048576;
    localparam logic [11:0] P_SCALE     = 12'd3125;

    // low 64 bits of a 64-bit word times a signed 16-bit word
    function automatic logic [63:0] mul64_s16(input logic [63:0] a, input logic [15:0] b);
        logic [79:0] full;
        full = a * b;
        return full[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'b0);
    endfunction

    // low 32 bits of a 32-bit word times a signed 16-bit word
    function automatic logic [31:0] mul32_s16(input logic [31:0] a, input logic [15:0] b);
        logic [47:0] full;
        full = a * b;
        return full[31:0] - (b[15] ? {a[15:0], 16'b0} : 32'b0);
    endfunction
endpackage
`default_nettype wire

// ----- design/baro_if.sv -----
// Interfaces: raw sample channel and compensated result channel.
`default_nettype none
interface baro_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    modport source (output valid, adc_temp, adc_press, input ready);
    modport sink   (input valid, adc_temp, adc_press, output ready);
endinterface

interface baro_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;
    modport source (output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                    input ready);
    modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_invalid,
                    output ready);
endinterface
`default_nettype wire

// ----- design/baro_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module baro_div #(
    parameter int W = 64,
    parameter int S = 34
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    input  wire logic [S-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quo,
    output logic [S-1:0]      o_side
);
    logic [W-1:0] r_nq   [W];   // dividend bits shift out, quotient bits shift in
    logic [W-1:0] r_rem  [W];
    logic [W-1:0] r_den  [W];
    logic [S-1:0] r_side [W];
    logic [W-1:0] r_vld;

    logic [W-1:0] n_nq  [W];
    logic [W-1:0] n_rem [W];

    // one compare-subtract: returns {remainder, shifted dividend with quotient bit}
    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] prem,
                                                 input logic [W-1:0] pnq,
                                                 input logic [W-1:0] pden);
        logic [W:0]   t;
        logic         ge;
        logic [W-1:0] rem;
        t   = {prem, pnq[W-1]};
        ge  = (t >= {1'b0, pden});
        rem = ge ? W'(t - {1'b0, pden}) : t[W-1:0];
        return {rem, pnq[W-2:0], ge};
    endfunction

    // one compare-subtract per stage
    always_comb begin
        {n_rem[0], n_nq[0]} = div_step('0, i_num, i_den);
        for (int k = 1; k < W; k++) begin
            {n_rem[k], n_nq[k]} = div_step(r_rem[k-1], r_nq[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < W; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < W; k++) begin
                r_nq[k]  <= n_nq[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_nq[W-1];
    assign o_side  = r_side[W-1];
endmodule
`default_nettype wire

// ----- design/baro_sensor_compensation.sv -----
// Top level: barometric temperature and pressure compensation pipeline.
// One sample word is taken every clock cycle unless the result side stalls; its result word
// passes 81 register stages, the output register included, most of them in the 64-stage
// divider that forms the pressure quotient. When the result side stalls, the whole pipeline
// holds and the input stalls with it. Calibration registers are written through the plain
// write port; the user must do so only while no sample is in flight: the block has no guard.
`default_nettype none
module baro_sensor_compensation (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [baro_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [baro_pkg::CFG_DATA_W-1:0] i_cfg_data,
    baro_in_if.sink                              i_sample,
    baro_out_if.source                           o_result
);
    import baro_pkg::*;

    // calibration registers
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_a, r_cal_b;
    logic [15:0] r_cal_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp <= '0;
            r_cal_a    <= '0;
            r_cal_b    <= '0;
            r_cal_p9   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAL_TEMP: r_cal_temp <= i_cfg_data[47:0];
                CFG_CAL_A:    r_cal_a    <= i_cfg_data;
                CFG_CAL_B:    r_cal_b    <= i_cfg_data;
                CFG_CAL_P9:   r_cal_p9   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8;
    assign t1 = r_cal_temp[15:0];
    assign t2 = r_cal_temp[31:16];
    assign t3 = r_cal_temp[47:32];
    assign p1 = r_cal_a[15:0];
    assign p2 = r_cal_a[31:16];
    assign p3 = r_cal_a[47:32];
    assign p4 = r_cal_a[63:48];
    assign p5 = r_cal_b[15:0];
    assign p6 = r_cal_b[31:16];
    assign p7 = r_cal_b[47:32];
    assign p8 = r_cal_b[63:48];

    // global advance: hold everything while the output word waits
    logic en;
    assign en = !o_result.valid || o_result.ready;
    assign i_sample.ready = en;

    localparam int PRE_N  = 11;
    localparam int POST_N = 6;
    logic [PRE_N-1:0]  r_vpre;
    logic [POST_N-1:0] r_vpost;
    logic              div_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre  <= '0;
            r_vpost <= '0;
        end else if (en) begin
            r_vpre  <= {r_vpre[PRE_N-2:0], i_sample.valid};
            r_vpost <= {r_vpost[POST_N-2:0], div_vld};
        end
    end

    // datapath registers
    logic [31:0] r1_a, r1_b, r2_v1t, r2_bb, r3_v1t, r3_m, r4_fine, r5_t5;
    logic [32:0] r5_v1;
    logic [31:0] r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [63:0] r6_sq, r6_v1p5, r6_v1p2, r7_sqp6, r7_sqp3, r7_v1p5, r7_v1p2;
    logic [63:0] r8_v2, r8_x, r9_xp1, r9_nm, r10_v1, r10_num, r11_un, r11_ud;
    logic        r11_inv, r11_neg;
    logic [RAW_W-1:0] r1_p, r2_p, r3_p, r4_p, r5_p, r6_p, r7_p, r8_p;

    logic [65:0] sq_full;
    logic [48:0] v1p5_full, v1p2_full;
    logic [79:0] xp1_full, num_full;
    logic [31:0] bb_sh, m_sh;
    assign sq_full   = 66'($signed(r5_v1) * $signed(r5_v1));
    assign v1p5_full = 49'($signed(r5_v1) * $signed(p5));
    assign v1p2_full = 49'($signed(r5_v1) * $signed(p2));
    assign xp1_full  = r8_x * p1;
    assign num_full  = r9_nm * P_SCALE;
    assign bb_sh     = $signed(r2_bb) >>> 12;
    assign m_sh      = $signed(r3_m) >>> 14;

    logic [63:0] sqp3_sh, nm_hi, v1_abs_n, num_abs_n;
    assign sqp3_sh   = $signed(r7_sqp3) >>> 8;
    assign nm_hi     = {12'b0, 21'(P_BASE - {1'b0, r8_p}), 31'b0};
    assign num_abs_n = r10_num[63] ? (64'b0 - r10_num) : r10_num;
    assign v1_abs_n  = r10_v1[63] ? (64'b0 - r10_v1) : r10_v1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // temperature path, 32-bit wrap
            r1_a    <= {15'b0, i_sample.adc_temp[19:3]} - {15'b0, t1, 1'b0};
            r1_b    <= {16'b0, i_sample.adc_temp[19:4]} - {16'b0, t1};
            r1_p    <= i_sample.adc_press;
            r2_v1t  <= $signed(mul32_s16(r1_a, t2)) >>> 11;
            r2_bb   <= 32'(r1_b * r1_b);
            r2_p    <= r1_p;
            r3_v1t  <= r2_v1t;
            r3_m    <= mul32_s16(bb_sh, t3);
            r3_p    <= r2_p;
            r4_fine <= r3_v1t + m_sh;
            r4_p    <= r3_p;
            r5_t5   <= {r4_fine[29:0], 2'b0} + r4_fine + 32'd128;
            r5_v1   <= {r4_fine[31], r4_fine} - FINE_OFFSET;
            r5_p    <= r4_p;
            // pressure path, 64-bit wrap
            r6_temp <= $signed(r5_t5) >>> 8;
            r6_sq   <= sq_full[63:0];
            r6_v1p5 <= {{15{v1p5_full[48]}}, v1p5_full};
            r6_v1p2 <= {{15{v1p2_full[48]}}, v1p2_full};
            r6_p    <= r5_p;
            r7_temp <= r6_temp;
            r7_sqp6 <= mul64_s16(r6_sq, p6);
            r7_sqp3 <= mul64_s16(r6_sq, p3);
            r7_v1p5 <= r6_v1p5;
            r7_v1p2 <= r6_v1p2;
            r7_p    <= r6_p;
            r8_temp <= r7_temp;
            r8_v2   <= r7_sqp6 + {r7_v1p5[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
            r8_x    <= (64'd1 << 47) + sqp3_sh + {r7_v1p2[51:0], 12'b0};
            r8_p    <= r7_p;
            r9_temp <= r8_temp;
            r9_xp1  <= xp1_full[63:0];
            r9_nm   <= nm_hi - r8_v2;
            r10_temp <= r9_temp;
            r10_v1  <= $signed(r9_xp1) >>> 33;
            r10_num <= num_full[63:0];
            // operand signs and magnitudes, invalid flag and temperature for the divider
            r11_temp <= r10_temp;
            r11_inv  <= (r10_v1 == 64'b0);
            r11_neg  <= r10_num[63] ^ r10_v1[63];
            r11_un   <= num_abs_n;
            r11_ud   <= v1_abs_n;
        end
    end

    logic [DIV_W-1:0]  quo;
    logic [SIDE_W-1:0] side;

    baro_div #(.W(DIV_W), .S(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vpre[PRE_N-1]),
        .i_num   (r11_un),
        .i_den   (r11_ud),
        .i_side  ({r11_temp, r11_inv, r11_neg}),
        .o_valid (div_vld),
        .o_quo   (quo),
        .o_side  (side)
    );

    // post-divide correction terms
    logic [31:0] q1_temp, q2_temp, q3_temp, q4_temp, q5_temp;
    logic        q1_inv, q2_inv, q3_inv, q4_inv, q5_inv;
    logic [63:0] q1_p, q2_p, q3_p, q4_p, q5_p;
    logic [63:0] q2_h, q2_g, q2_w2, q3_h, q3_g, q3_w2, q3_m0, q4_m0, q4_w2, q5_w1, q5_w2;
    logic [31:0] q4_cross;
    logic [31:0] r_out_temp, r_out_press;
    logic        r_out_inv;

    logic [63:0] h_n, m0_sum, p_sum, p_fin;
    assign h_n    = $signed(q1_p) >>> 13;
    assign m0_sum = q4_m0 + {q4_cross, 32'b0};
    assign p_sum  = q5_p + q5_w1 + q5_w2;
    assign p_fin  = ($signed(p_sum) >>> 8) + {{44{p7[15]}}, p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            q1_temp  <= side[SIDE_W-1:2];
            q1_inv   <= side[1];
            q1_p     <= side[0] ? (64'b0 - quo) : quo;
            q2_temp  <= q1_temp;
            q2_inv   <= q1_inv;
            q2_p     <= q1_p;
            q2_h     <= h_n;
            q2_g     <= mul64_s16(h_n, r_cal_p9);
            q2_w2    <= $signed(mul64_s16(q1_p, p8)) >>> 19;
            q3_temp  <= q2_temp;
            q3_inv   <= q2_inv;
            q3_p     <= q2_p;
            q3_h     <= q2_h;
            q3_g     <= q2_g;
            q3_w2    <= q2_w2;
            q3_m0    <= q2_g[31:0] * q2_h[31:0];
            q4_temp  <= q3_temp;
            q4_inv   <= q3_inv;
            q4_p     <= q3_p;
            q4_w2    <= q3_w2;
            q4_m0    <= q3_m0;
            q4_cross <= 32'(q3_g[31:0] * q3_h[63:32]) + 32'(q3_g[63:32] * q3_h[31:0]);
            q5_temp  <= q4_temp;
            q5_inv   <= q4_inv;
            q5_p     <= q4_p;
            q5_w2    <= q4_w2;
            q5_w1    <= $signed(m0_sum) >>> 25;
            // output word
            r_out_temp  <= q5_temp;
            r_out_inv   <= q5_inv;
            r_out_press <= q5_inv ? 32'b0 : p_fin[31:0];
        end
    end

    assign o_result.valid             = r_vpost[POST_N-1];
    assign o_result.temperature_centi = r_out_temp;
    assign o_result.pressure_q24_8    = r_out_press;
    assign o_result.pressure_invalid  = r_out_inv;

    // checks
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.pressure_invalid |-> o_result.pressure_q24_8 == 32'b0)
        else $error("invalid pressure word carries nonzero value");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && i_sample.ready |=> r_vpre[0])
        else $error("accepted sample did not enter pipeline");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vpre) && $stable(r_vpost))
        else $error("pipeline moved during stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !o_result.valid && r_vpre == '0)
        else $error("pipeline not empty after reset");
endmodule
`default_nettype wire
